### hw/rtl/rme_pkg.sv
// Package for the rotation-matrix-to-Euler block: widths, the CORDIC arctangent table
// and the stage record type. No dependencies.
`default_nettype none
package rme_pkg;
  localparam int InW      = 16;
  localparam int SqW      = 32;
  localparam int SyW      = 16;
  localparam int VecW     = 34;
  localparam int AngW     = 34;
  localparam int OutW     = 16;
  localparam int ThrW     = 15;
  localparam int TabLen   = 30;
  localparam logic signed [AngW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [OutW-1:0] AngleMax  = 16'sd25736;

  function automatic logic signed [AngW-1:0] atan_tab(input int i);
    logic [31:0] v;
    begin
      case (i)
        0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
        3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
        6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
        9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
        12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
        15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
        18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
        21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
        24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
        27: v = 32'h00000008; 28: v = 32'h00000004; 29: v = 32'h00000002;
        default: v = 32'h0;
      endcase
      return signed'({2'b00, v});
    end
  endfunction

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
    logic                   zero;
  } cordic_t;
endpackage
`default_nettype wire

### hw/rtl/rme_if.sv
// Channel interfaces for the rotation-matrix-to-Euler block.
// Depends on nothing but the widths written here.
`default_nettype none
interface rme_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] r00, r10, r20, r21, r22, r12, r11;
  modport source (output valid, r00, r10, r20, r21, r22, r12, r11, input ready);
  modport sink   (input valid, r00, r10, r20, r21, r22, r12, r11, output ready);
endinterface

interface rme_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] angle_x, angle_y, angle_z;
  logic is_singular;
  modport source (output valid, angle_x, angle_y, angle_z, is_singular, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, is_singular, output ready);
endinterface
`default_nettype wire

### hw/rtl/rotation_matrix_to_euler.sv
// Top level of the rotation-matrix-to-Euler block: square sum, pipelined square root,
// three CORDIC vectoring pipelines. Depends on rme_pkg and rme_if.
//
//   channel  direction  payload
//   in       sink       r00 r10 r20 r21 r22 r12 r11 (Q2.14)
//   out      source     angle_x angle_y angle_z (Q3.13), is_singular
//   cfg      write      singular_threshold (UQ1.14, 15 bits)
//
// One request enters per cycle while the output register is free. The stages are:
// squares, a 16-stage root (one result bit per stage), the branch choice,
// CORDIC setup, one stage per CORDIC step, and rounding into the output register.
// The whole pipeline advances together on a free output register, so a stall
// freezes every stage and nothing is lost. Reset clears the valid bits and sets the
// threshold to one LSB.
`default_nettype none
module rotation_matrix_to_euler
  import rme_pkg::*;
#(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [ThrW-1:0] cfg_wdata,
  rme_in_if.sink               in,
  rme_out_if.source            out
);
  localparam int NIter = (ANGLE_ITERATIONS > TabLen) ? TabLen : ANGLE_ITERATIONS;
  localparam int SqStg = 16;

  logic [ThrW-1:0] singular_threshold;
  always_ff @(posedge clk) begin
    if (rst) singular_threshold <= ThrW'(1);
    else if (cfg_we) singular_threshold <= cfg_wdata;
  end

  // The single output register decides whether everything moves.
  logic adv;
  assign adv      = !out.valid || out.ready;
  assign in.ready = adv;

  // Stage 1: capture inputs. Stage 2: squares summed.
  logic                   v1;
  logic signed [InW-1:0]  a00, a10, a20, a21, a22, a12, a11;
  logic                   v2;
  logic [SqW-1:0]         sq2;
  logic signed [InW-1:0]  b00, b10, b20, b21, b22, b12, b11;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0;
    end else if (adv) begin
      v1 <= in.valid; v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a00 <= in.r00; a10 <= in.r10; a20 <= in.r20; a21 <= in.r21;
      a22 <= in.r22; a12 <= in.r12; a11 <= in.r11;
      sq2 <= SqW'(a00 * a00) + SqW'(a10 * a10);
      b00 <= a00; b10 <= a10; b20 <= a20; b21 <= a21;
      b22 <= a22; b12 <= a12; b11 <= a11;
    end
  end

  // Integer square root, one result bit per stage (restoring).
  logic [SqStg:0]         sv;
  logic [SqW-1:0]         srem [SqStg+1];
  logic [SyW-1:0]         sres [SqStg+1];
  logic signed [InW-1:0]  s00 [SqStg+1], s10 [SqStg+1], s20 [SqStg+1], s21 [SqStg+1];
  logic signed [InW-1:0]  s22 [SqStg+1], s12 [SqStg+1], s11 [SqStg+1];
  assign sv[0]   = v2;
  assign srem[0] = sq2;
  assign sres[0] = '0;
  assign s00[0] = b00; assign s10[0] = b10; assign s20[0] = b20; assign s21[0] = b21;
  assign s22[0] = b22; assign s12[0] = b12; assign s11[0] = b11;

  for (genvar k = 0; k < SqStg; k++) begin : g_sqrt
    localparam int Bit = SqStg - 1 - k;
    logic [SqW+1:0] trial;
    logic [SqW+1:0] rem_sh;
    always_comb begin
      rem_sh = {2'b00, srem[k]} >> (2 * Bit);
      trial  = {({(SqW+2-SyW)'(0), sres[k]}) << 2} | (SqW+2)'(1);
    end
    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else if (adv) sv[k+1] <= sv[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_sh >= trial) begin
          srem[k+1] <= srem[k] - SqW'(trial << (2 * Bit));
          sres[k+1] <= {sres[k][SyW-2:0], 1'b1};
        end else begin
          srem[k+1] <= srem[k];
          sres[k+1] <= {sres[k][SyW-2:0], 1'b0};
        end
        s00[k+1] <= s00[k]; s10[k+1] <= s10[k]; s20[k+1] <= s20[k];
        s21[k+1] <= s21[k]; s22[k+1] <= s22[k]; s12[k+1] <= s12[k];
        s11[k+1] <= s11[k];
      end
    end
  end

  // Branch choice: operands (a, b) of each of the three arctangents, 18 bits signed.
  localparam int OpW = 18;
  logic                  vb, sing_b;
  logic signed [OpW-1:0] xa, xb, ya, yb, za, zb;
  logic                  sing;
  assign sing = {1'b0, sres[SqStg]} < {2'b00, singular_threshold};
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (adv) vb <= sv[SqStg];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sing_b <= sing;
      ya <= -OpW'(s20[SqStg]);
      yb <= signed'({2'b00, sres[SqStg]});
      if (sing) begin
        xa <= -OpW'(s12[SqStg]); xb <= OpW'(s11[SqStg]);
        za <= '0; zb <= '0;
      end else begin
        xa <= OpW'(s21[SqStg]); xb <= OpW'(s22[SqStg]);
        za <= OpW'(s10[SqStg]); zb <= OpW'(s00[SqStg]);
      end
    end
  end

  // CORDIC setup: scale by 2^14 and fold the left half-plane.
  function automatic cordic_t cor_setup(input logic signed [OpW-1:0] a,
                                        input logic signed [OpW-1:0] b);
    cordic_t r;
    logic signed [VecW-1:0] x0, y0;
    begin
      x0 = VecW'(b) <<< 14;
      y0 = VecW'(a) <<< 14;
      r.zero = (a == '0) && (b == '0);
      r.x = x0; r.y = y0; r.z = '0;
      if (x0 < 0) begin
        if (y0 >= 0) begin
          r.x = y0; r.y = -x0; r.z = HalfPiQ30;
        end else begin
          r.x = -y0; r.y = x0; r.z = -HalfPiQ30;
        end
      end
      return r;
    end
  endfunction

  function automatic cordic_t cor_step(input cordic_t c, input int i);
    cordic_t r;
    logic signed [VecW-1:0] dx, dy;
    begin
      r  = c;
      dx = c.y >>> i;
      dy = c.x >>> i;
      if (c.y > 0) begin
        r.x = c.x + dx; r.y = c.y - dy; r.z = c.z + atan_tab(i);
      end else begin
        r.x = c.x - dx; r.y = c.y + dy; r.z = c.z - atan_tab(i);
      end
      return r;
    end
  endfunction

  function automatic logic signed [OutW-1:0] cor_round(input cordic_t c);
    logic signed [AngW-1:0] t;
    begin
      t = (c.z + AngW'(65536)) >>> 17;
      if (c.zero) return '0;
      if (t > AngW'(AngleMax)) return AngleMax;
      if (t < -AngW'(AngleMax)) return -AngleMax;
      return OutW'(t);
    end
  endfunction

  logic [NIter:0] cv;
  logic [NIter:0] cs;
  cordic_t cx [NIter+1], cy [NIter+1], cz [NIter+1];
  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else if (adv) cv[0] <= vb;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      cs[0] <= sing_b;
      cx[0] <= cor_setup(xa, xb);
      cy[0] <= cor_setup(ya, yb);
      cz[0] <= cor_setup(za, zb);
    end
  end

  for (genvar i = 0; i < NIter; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else if (adv) cv[i+1] <= cv[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cs[i+1] <= cs[i];
        cx[i+1] <= cor_step(cx[i], i);
        cy[i+1] <= cor_step(cy[i], i);
        cz[i+1] <= cor_step(cz[i], i);
      end
    end
  end

  // Output register: round, hold to range, force z to zero when singular.
  always_ff @(posedge clk) begin
    if (rst) out.valid <= 1'b0;
    else if (adv) out.valid <= cv[NIter];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out.angle_x     <= cor_round(cx[NIter]);
      out.angle_y     <= cor_round(cy[NIter]);
      out.angle_z     <= cs[NIter] ? '0 : cor_round(cz[NIter]);
      out.is_singular <= cs[NIter];
    end
  end
endmodule
`default_nettype wire
